@@ rtl/indexed_pixel_palette_unpacker_defines.svh @@
// Assertion macros shared by the indexed pixel palette unpacker.
`ifndef INDEXED_PIXEL_PALETTE_UNPACKER_DEFINES_SVH
`define INDEXED_PIXEL_PALETTE_UNPACKER_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define IPP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define IPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ipp_pkg.sv @@
// Package of types, constants and the brightness function for the palette unpacker.
package ipp_pkg;

  localparam int DEF_MAX_LEDS      = 1024;
  localparam int DEF_PALETTE_DEPTH = 256;
  localparam int OQ_DEPTH          = 4;
  localparam int LEN_W             = 13;
  localparam int LED_W             = 10;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DATA = 1'b1;

  localparam logic [1:0] REG_INDEXED_MODE   = 2'd0;
  localparam logic [1:0] REG_PALETTE_SIZE   = 2'd1;
  localparam logic [1:0] REG_LEDS_PER_FRAME = 2'd2;

  typedef enum logic [1:0] {BPP_1, BPP_2, BPP_4, BPP_8} bpp_t;
  typedef enum logic [1:0] {PH_RED, PH_GREEN, PH_BLUE} phase_t;

  typedef struct packed {
    logic        en;
    logic [7:0]  addr;
    logic [23:0] color;
  } pal_wr_t;

  typedef struct packed {
    logic             valid;
    logic             use_mem;
    logic             black;
    logic [7:0]       idx;
    logic [23:0]      color;
    logic [LED_W-1:0] led_index;
    logic             frame_end;
    logic             last;
  } pix_req_t;

  typedef struct packed {
    logic             last;
    logic             frame_end;
    logic [7:0]       blue;
    logic [7:0]       green;
    logic [7:0]       red;
    logic [LED_W-1:0] led_index;
  } result_t;

  // round(v * 150 / 255), the divide by 255 done as (y + (y >> 8)) >> 8 with y = x + 1.
  function automatic logic [7:0] bright(input logic [7:0] v);
    logic [15:0] t;
    logic [16:0] u;
    t = 16'(v) * 16'd150 + 16'd127;
    u = 17'(t) + 17'd1;
    return 8'((u + (u >> 8)) >> 8);
  endfunction

endpackage

@@ rtl/ipp_issue.sv @@
// Request register, pixel unpacker, frame position counter and configuration registers.
module ipp_issue #(
  parameter int MAX_LEDS      = ipp_pkg::DEF_MAX_LEDS,
  parameter int PALETTE_DEPTH = ipp_pkg::DEF_PALETTE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cmd,
  input  logic [39:0]        in_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [10:0]        cfg_wdata,
  input  logic               slot_ok,
  output ipp_pkg::pal_wr_t   wr,
  output ipp_pkg::pix_req_t  req
);
  import ipp_pkg::*;

  localparam int CW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

  logic          busy_r;
  logic          cmd_r;
  logic          ind_r;
  logic [7:0]    pidx_r;
  logic [7:0]    raw_r_r, raw_g_r, raw_b_r;
  logic [7:0]    byte_r;
  logic [2:0]    left_r;
  bpp_t          bpp_r;
  phase_t        phase_r, phase_nxt;
  logic [7:0]    held_red_r, held_green_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          indexed_mode_r;
  logic [8:0]    palette_size_r;
  logic [10:0]   leds_per_frame_r;

  bpp_t          bpp_new;
  logic [2:0]    left_new;
  logic [7:0]    cur_idx;
  logic [7:0]    byte_shifted;
  logic [LEN_W-1:0] frame_len;
  logic          frame_end;
  logic          need_slot, step, final_step, accept, full_step;

  always_comb begin
    if (palette_size_r <= 9'd2) begin
      bpp_new = BPP_1;
    end else if (palette_size_r <= 9'd4) begin
      bpp_new = BPP_2;
    end else if (palette_size_r <= 9'd16) begin
      bpp_new = BPP_4;
    end else begin
      bpp_new = BPP_8;
    end
  end

  always_comb begin
    unique case (bpp_new)
      BPP_1:   left_new = 3'd7;
      BPP_2:   left_new = 3'd3;
      BPP_4:   left_new = 3'd1;
      default: left_new = 3'd0;
    endcase
  end

  always_comb begin
    unique case (bpp_r)
      BPP_1: begin
        cur_idx      = {7'd0, byte_r[0]};
        byte_shifted = byte_r >> 1;
      end
      BPP_2: begin
        cur_idx      = {6'd0, byte_r[1:0]};
        byte_shifted = byte_r >> 2;
      end
      BPP_4: begin
        cur_idx      = {4'd0, byte_r[3:0]};
        byte_shifted = byte_r >> 4;
      end
      default: begin
        cur_idx      = byte_r;
        byte_shifted = 8'd0;
      end
    endcase
  end

  always_comb begin
    if (leds_per_frame_r == 11'd0) begin
      frame_len = LEN_W'(1);
    end else if (LEN_W'(leds_per_frame_r) > LEN_W'(MAX_LEDS)) begin
      frame_len = LEN_W'(MAX_LEDS);
    end else begin
      frame_len = LEN_W'(leds_per_frame_r);
    end
    frame_end = (LEN_W'(cnt_r) + LEN_W'(1)) >= frame_len;
    cnt_nxt   = frame_end ? '0 : cnt_r + CW'(1);
  end

  always_comb begin
    need_slot  = (cmd_r == CMD_DATA) && (ind_r || (phase_r == PH_BLUE));
    step       = busy_r && (!need_slot || slot_ok);
    final_step = step && (!ind_r || (left_r == 3'd0));
    in_ready   = !busy_r || final_step;
    accept     = in_valid && in_ready;
    full_step  = step && (cmd_r == CMD_DATA) && !ind_r;

    wr.en    = step && (cmd_r == CMD_LOAD) && (9'(pidx_r) < 9'(PALETTE_DEPTH));
    wr.addr  = pidx_r;
    wr.color = {bright(raw_r_r), bright(raw_g_r), bright(raw_b_r)};

    req.valid     = step && need_slot;
    req.use_mem   = ind_r;
    req.idx       = cur_idx;
    req.black     = 9'(cur_idx) >= 9'(PALETTE_DEPTH);
    req.color     = {held_red_r, held_green_r, bright(byte_r)};
    req.led_index = LED_W'(cnt_r);
    req.frame_end = frame_end;
    req.last      = ind_r ? (left_r == 3'd0) : 1'b1;
  end

  always_comb begin
    phase_nxt = phase_r;
    if (full_step) begin
      unique case (phase_r)
        PH_RED:   phase_nxt = PH_GREEN;
        PH_GREEN: phase_nxt = PH_BLUE;
        default:  phase_nxt = PH_RED;
      endcase
    end
    if (cfg_we && (cfg_addr == REG_INDEXED_MODE)) begin
      phase_nxt = PH_RED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r           <= 1'b0;
      phase_r          <= PH_RED;
      cnt_r            <= '0;
      held_red_r       <= 8'd0;
      held_green_r     <= 8'd0;
      indexed_mode_r   <= 1'b0;
      palette_size_r   <= 9'd256;
      leds_per_frame_r <= 11'd64;
    end else begin
      phase_r <= phase_nxt;
      if (accept) begin
        busy_r <= 1'b1;
      end else if (final_step) begin
        busy_r <= 1'b0;
      end
      if (req.valid) begin
        cnt_r <= cnt_nxt;
      end
      if (full_step && (phase_r == PH_RED)) begin
        held_red_r <= bright(byte_r);
      end
      if (full_step && (phase_r == PH_GREEN)) begin
        held_green_r <= bright(byte_r);
      end
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_INDEXED_MODE:   indexed_mode_r   <= cfg_wdata[0];
          REG_PALETTE_SIZE:   palette_size_r   <= cfg_wdata[8:0];
          REG_LEDS_PER_FRAME: leds_per_frame_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_cmd;
      ind_r   <= (in_cmd == CMD_DATA) && indexed_mode_r;
      pidx_r  <= in_data[7:0];
      raw_r_r <= in_data[15:8];
      raw_g_r <= in_data[23:16];
      raw_b_r <= in_data[31:24];
      byte_r  <= in_data[39:32];
      left_r  <= left_new;
      bpp_r   <= bpp_new;
    end else if (step && ind_r) begin
      byte_r <= byte_shifted;
      left_r <= left_r - 3'd1;
    end
  end

endmodule

@@ rtl/ipp_palette.sv @@
// Palette memory with its registered read stage and colour selection.
module ipp_palette #(
  parameter int PALETTE_DEPTH = ipp_pkg::DEF_PALETTE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ipp_pkg::pal_wr_t   wr,
  input  ipp_pkg::pix_req_t  req,
  output logic               res_valid,
  output ipp_pkg::result_t   res
);
  import ipp_pkg::*;

  localparam int AW = $clog2(PALETTE_DEPTH);

  logic [23:0] mem [PALETTE_DEPTH];
  logic [23:0] rd_r;
  pix_req_t    meta_r;
  logic        v_r;
  logic [23:0] color;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= wr.color;
    end
    if (req.valid) begin
      rd_r   <= mem[req.idx[AW-1:0]];
      meta_r <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= req.valid;
    end
  end

  always_comb begin
    if (!meta_r.use_mem) begin
      color = meta_r.color;
    end else if (meta_r.black) begin
      color = 24'd0;
    end else begin
      color = rd_r;
    end
    res_valid     = v_r;
    res.last      = meta_r.last;
    res.frame_end = meta_r.frame_end;
    res.red       = color[23:16];
    res.green     = color[15:8];
    res.blue      = color[7:0];
    res.led_index = meta_r.led_index;
  end

endmodule

@@ rtl/ipp_outq.sv @@
// Small result queue that decouples the pixel pipeline from the output stream.
module ipp_outq (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  ipp_pkg::result_t                    push_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ipp_pkg::result_t                    out_data,
  output logic [$clog2(ipp_pkg::OQ_DEPTH):0]  count
);
  import ipp_pkg::*;

  localparam int PW = $clog2(OQ_DEPTH);

  result_t       q [OQ_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;
  logic          pop;

  always_comb begin
    out_valid = cnt_r != '0;
    out_data  = q[rp_r];
    pop       = out_valid && out_ready;
    count     = cnt_r;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + PW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + PW'(1);
      end
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

@@ rtl/indexed_pixel_palette_unpacker.sv @@
// Top level of the indexed pixel palette unpacker.
// A data request's first pixel passes the request, palette read and queue registers in turn.
// Pixels are issued at one per cycle while the result queue has room; a byte at 1, 2, 4 or 8
// bits per pixel yields 8, 4, 2 or 1 pixels, and the next request is taken with its last one.
// Reset (synchronous, active low) clears queue and counters, presets config, keeps palette.
`include "indexed_pixel_palette_unpacker_defines.svh"

module indexed_pixel_palette_unpacker #(
  parameter int MAX_LEDS      = ipp_pkg::DEF_MAX_LEDS,
  parameter int PALETTE_DEPTH = ipp_pkg::DEF_PALETTE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // palette_index, red_in, green_in, blue_in, data_byte
  input  logic [39:0] in_tdata,
  // command
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // led_index, red_out, green_out, blue_out, then zero fill
  output logic [39:0] out_tdata,
  // frame_end
  output logic        out_tuser,
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [10:0] cfg_wdata
);
  import ipp_pkg::*;

  localparam int QW = $clog2(OQ_DEPTH) + 1;

  pal_wr_t         wr;
  pix_req_t        pix_req;
  logic            slot_ok;
  logic            res_valid;
  result_t         res;
  result_t         head;
  logic [QW-1:0]   oq_cnt;
  logic            oq_pop;

  assign slot_ok = (oq_cnt + QW'(res_valid)) < QW'(OQ_DEPTH);
  assign oq_pop  = out_tvalid && out_tready;

  ipp_issue #(
    .MAX_LEDS      (MAX_LEDS),
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_issue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_tuser),
    .in_data   (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .slot_ok   (slot_ok),
    .wr        (wr),
    .req       (pix_req)
  );

  ipp_palette #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .req       (pix_req),
    .res_valid (res_valid),
    .res       (res)
  );

  ipp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (head),
    .count     (oq_cnt)
  );

  assign out_tdata = {6'd0, head.blue, head.green, head.red, head.led_index};
  assign out_tuser = head.frame_end;
  assign out_tlast = head.last;

  `IPP_ASSERT_IMPL(a_oq_no_overflow, res_valid && !oq_pop, oq_cnt < QW'(OQ_DEPTH), "result queue overflow")
  `IPP_ASSERT_NEXT(a_pixel_reaches_queue, pix_req.valid, res_valid, "issued pixel lost before the queue")
  `IPP_ASSERT_IMPL(a_load_no_pixel, wr.en, !pix_req.valid, "palette load issued a pixel")

endmodule
